// File: hdl/spms_pkg.sv
// Package for the shortest-path search: sizes, payload structs, register map, control types.
`timescale 1ns / 1ps
package spms_pkg;

  localparam int MaxNodes  = 16;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CountW    = 5;
  localparam int WeightW   = 16;
  localparam int DistW     = 20;
  localparam int MatDepth  = MaxNodes * MaxNodes;
  localparam int MatW      = WeightW + 1;
  localparam int ApbAddrW  = 4;
  localparam int ApbDataW  = 32;

  localparam logic [DistW-1:0] DistMax = '1;

  // Register word indexes (paddr[3:2])
  localparam logic [1:0] RegNodeCount  = 2'd0;
  localparam logic [1:0] RegStartNode  = 2'd1;
  localparam logic [1:0] RegTargetNode = 2'd2;

  localparam logic [CountW-1:0] NodeCountRst  = CountW'(16);
  localparam logic [NodeW-1:0]  StartNodeRst  = NodeW'(0);
  localparam logic [NodeW-1:0]  TargetNodeRst = NodeW'(15);

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] edge_weight;
    logic        has_edge;
    logic        start_search;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  node_index;
    logic [19:0] distance;
    logic        reachable;
    logic [3:0]  predecessor;
    logic        settled;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_RELAX,
    ST_RELAX_END,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic init;
    logic scan_en;
    logic relax_en;
    logic mark_en;
    logic emit_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic found;
    logic sel_is_target;
  } ctrl_sts_t;

endpackage

// File: hdl/spms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/spms_dp.sv
// Datapath: matrix memory, per-node distance state, selection scan, relaxation and result register.
`timescale 1ns / 1ps
module spms_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  spms_pkg::in_item_t         item_i,
  input  logic [spms_pkg::NodeW-1:0] start_node_i,
  input  logic [spms_pkg::NodeW-1:0] target_node_i,
  input  logic [spms_pkg::NodeW-1:0] node_last_i,
  input  spms_pkg::ctrl_cmd_t        cmd_i,
  output spms_pkg::ctrl_sts_t        sts_o,
  output logic                       result_strobe_o,
  output spms_pkg::out_item_t        result_o
);

  logic [spms_pkg::DistW-1:0]    dist_q [spms_pkg::MaxNodes];
  logic [spms_pkg::NodeW-1:0]    pred_q [spms_pkg::MaxNodes];
  logic [spms_pkg::MaxNodes-1:0] known_q;
  logic [spms_pkg::MaxNodes-1:0] visited_q;

  logic [spms_pkg::NodeW-1:0] cnt_q;
  logic [spms_pkg::NodeW-1:0] sel_q;
  logic [spms_pkg::DistW-1:0] best_q;
  logic                       found_q;
  logic                       rel_vld_q;
  logic [spms_pkg::NodeW-1:0] rel_idx_q;
  logic                       strobe_q;
  spms_pkg::out_item_t        result_q;

  logic [spms_pkg::MatW-1:0]  mat_rdata;
  logic [spms_pkg::NodeW-1:0] rd_idx;
  logic [spms_pkg::DistW-1:0] rd_dist;
  logic                       rd_known;
  logic                       rd_vis;
  logic [spms_pkg::NodeW-1:0] rd_pred;
  logic                       cnt_last;
  logic                       scan_take;
  logic [spms_pkg::DistW:0]   cost_sum;
  logic [spms_pkg::DistW-1:0] cost;
  logic                       relax_upd;

  spms_ram #(
    .Width(spms_pkg::MatW),
    .Depth(spms_pkg::MatDepth)
  ) u_mat (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i({item_i.row_index, item_i.col_index}),
    .wdata_i({item_i.has_edge, item_i.edge_weight}),
    .raddr_i({sel_q, cnt_q}),
    .rdata_o(mat_rdata)
  );

  // The node state is read at one place per cycle: the pending relax entry, else the counter
  always_comb begin
    rd_idx   = rel_vld_q ? rel_idx_q : cnt_q;
    rd_dist  = dist_q[rd_idx];
    rd_known = known_q[rd_idx];
    rd_vis   = visited_q[rd_idx];
    rd_pred  = pred_q[rd_idx];
    cnt_last = (cnt_q == node_last_i);

    scan_take = !rd_vis && rd_known && (!found_q || (rd_dist < best_q));

    cost_sum = {1'b0, best_q} + (spms_pkg::DistW + 1)'(mat_rdata[spms_pkg::WeightW-1:0]);
    cost     = cost_sum[spms_pkg::DistW] ? spms_pkg::DistMax : cost_sum[spms_pkg::DistW-1:0];

    relax_upd = rel_vld_q && !rd_vis && mat_rdata[spms_pkg::WeightW] &&
                (!rd_known || (rd_dist > cost));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spms_pkg::MaxNodes; i++) begin
        dist_q[i] <= '0;
        pred_q[i] <= '0;
      end
      known_q   <= '0;
      visited_q <= '0;
      cnt_q     <= '0;
      sel_q     <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      rel_vld_q <= 1'b0;
      rel_idx_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      rel_vld_q <= cmd_i.relax_en;
      rel_idx_q <= cnt_q;
      strobe_q  <= cmd_i.emit_en;

      if (cmd_i.init) begin
        for (int i = 0; i < spms_pkg::MaxNodes; i++) begin
          dist_q[i] <= '0;
          pred_q[i] <= '0;
        end
        known_q   <= spms_pkg::MaxNodes'(1) << start_node_i;
        visited_q <= '0;
        cnt_q     <= '0;
        found_q   <= 1'b0;
      end

      if (cmd_i.scan_en || cmd_i.relax_en || cmd_i.emit_en) begin
        cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
      end

      if (cmd_i.scan_en && scan_take) begin
        sel_q   <= cnt_q;
        best_q  <= rd_dist;
        found_q <= 1'b1;
      end

      if (relax_upd) begin
        dist_q[rel_idx_q]  <= cost;
        known_q[rel_idx_q] <= 1'b1;
        pred_q[rel_idx_q]  <= sel_q;
      end

      if (cmd_i.mark_en) begin
        visited_q[sel_q] <= 1'b1;
        found_q          <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      result_q.node_index  <= cnt_q;
      result_q.distance    <= rd_known ? rd_dist : '0;
      result_q.reachable   <= rd_known;
      result_q.predecessor <= rd_known ? rd_pred : '0;
      result_q.settled     <= rd_vis;
      result_q.last_result <= cnt_last;
    end
  end

  assign sts_o.cnt_last      = cnt_last;
  assign sts_o.found         = found_q;
  assign sts_o.sel_is_target = (sel_q == target_node_i);
  assign result_strobe_o     = strobe_q;
  assign result_o            = result_q;

endmodule

// File: hdl/spms_ctrl.sv
// Controller: sequences init, selection scans, relax passes and result emission.
`timescale 1ns / 1ps
module spms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                search_i,
  input  spms_pkg::ctrl_sts_t sts_i,
  output spms_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o
);

  spms_pkg::state_e state_q;
  spms_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spms_pkg::ST_IDLE: begin
        if (start_i && search_i) begin
          state_d = spms_pkg::ST_SCAN;
        end
      end
      spms_pkg::ST_SCAN: begin
        if (sts_i.cnt_last) begin
          state_d = spms_pkg::ST_SCAN_CHK;
        end
      end
      spms_pkg::ST_SCAN_CHK: begin
        if (!sts_i.found || sts_i.sel_is_target) begin
          state_d = spms_pkg::ST_EMIT;
        end else begin
          state_d = spms_pkg::ST_RELAX;
        end
      end
      spms_pkg::ST_RELAX: begin
        if (sts_i.cnt_last) begin
          state_d = spms_pkg::ST_RELAX_END;
        end
      end
      spms_pkg::ST_RELAX_END: begin
        state_d = spms_pkg::ST_SCAN;
      end
      spms_pkg::ST_EMIT: begin
        if (sts_i.cnt_last) begin
          state_d = spms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      spms_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.init = start_i && search_i;
      end
      spms_pkg::ST_SCAN:      cmd_o.scan_en  = 1'b1;
      spms_pkg::ST_SCAN_CHK:  cmd_o          = '0;
      spms_pkg::ST_RELAX:     cmd_o.relax_en = 1'b1;
      // last relax entry completes here while the selected node is settled
      spms_pkg::ST_RELAX_END: cmd_o.mark_en  = 1'b1;
      spms_pkg::ST_EMIT:      cmd_o.emit_en  = 1'b1;
      default:                cmd_o          = '0;
    endcase
  end

endmodule

// File: hdl/shortest_path_matrix_search.sv
// Top level: configuration registers, controller and datapath of the shortest-path search.
`timescale 1ns / 1ps
// Shortest-path search over a weighted adjacency matrix of up to 16 nodes.
// Input channel: an item (one matrix entry) transfers at a clock edge with start high
// and busy low. An entry without start_search is stored and busy stays low.
// An entry with start_search is stored and then starts a search from start_node.
// The search runs in rounds: a selection scan over the n nodes in use,
// then, unless nothing is finite or the target was picked, a relax pass
// that reads one matrix entry per cycle from the single memory read port.
// After the search, n results follow on consecutive cycles, node 0 first.
// Each result stands for exactly one cycle with result_strobe_o high; the receiver
// cannot stall, so no result is ever held back. last_result marks node n-1.
// busy falls at the edge that registers the last result, so it is low while it is shown.
// Configuration: APB registers node_count (0x0), start_node (0x4), target_node (0x8),
// written by the user only while busy is low; not enforced. pready is always high.
// Reset: no search pending, registers to 16 / 0 / 15; matrix contents are undefined
// until written, so every entry a search reads must be loaded first.
module shortest_path_matrix_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  spms_pkg::in_item_t            item_i,
  output logic                          result_strobe_o,
  output spms_pkg::out_item_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spms_pkg::ApbAddrW-1:0] paddr,
  input  logic [spms_pkg::ApbDataW-1:0] pwdata,
  output logic [spms_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  logic [spms_pkg::CountW-1:0] node_count_q;
  logic [spms_pkg::NodeW-1:0]  start_node_q;
  logic [spms_pkg::NodeW-1:0]  target_node_q;

  logic                        cfg_wr;
  logic                        accept;
  logic [spms_pkg::CountW-1:0] nodes_used;
  logic [spms_pkg::NodeW-1:0]  node_last;

  spms_pkg::ctrl_cmd_t cmd;
  spms_pkg::ctrl_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= spms_pkg::NodeCountRst;
      start_node_q  <= spms_pkg::StartNodeRst;
      target_node_q <= spms_pkg::TargetNodeRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        spms_pkg::RegNodeCount:  node_count_q  <= pwdata[spms_pkg::CountW-1:0];
        spms_pkg::RegStartNode:  start_node_q  <= pwdata[spms_pkg::NodeW-1:0];
        spms_pkg::RegTargetNode: target_node_q <= pwdata[spms_pkg::NodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spms_pkg::RegNodeCount:  prdata = spms_pkg::ApbDataW'(node_count_q);
      spms_pkg::RegStartNode:  prdata = spms_pkg::ApbDataW'(start_node_q);
      spms_pkg::RegTargetNode: prdata = spms_pkg::ApbDataW'(target_node_q);
      default:                 prdata = '0;
    endcase
  end

  // zero counts as one node, larger counts clamp to the matrix size
  always_comb begin
    if (node_count_q == '0) begin
      nodes_used = spms_pkg::CountW'(1);
    end else if (node_count_q > spms_pkg::CountW'(spms_pkg::MaxNodes)) begin
      nodes_used = spms_pkg::CountW'(spms_pkg::MaxNodes);
    end else begin
      nodes_used = node_count_q;
    end
    node_last = spms_pkg::NodeW'(nodes_used - 1'b1);
  end

  spms_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .search_i(item_i.start_search),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  spms_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (accept),
    .item_i         (item_i),
    .start_node_i   (start_node_q),
    .target_node_i  (target_node_q),
    .node_last_i    (node_last),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

endmodule

// File: tb/sv/shortest_path_matrix_search_tb.sv
// Self-checking testbench for shortest_path_matrix_search: matrix loads, searches, APB config.
`timescale 1ns / 1ps
module shortest_path_matrix_search_tb;
  import spms_pkg::*;

  localparam int ItemsTarget = 280;
  localparam int IdleLimit   = 4000;
  localparam int DirRows     = 18;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            item_i = '0;
  logic                result_strobe_o;
  out_item_t           result_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  shortest_path_matrix_search uut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_strobe_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block: matrix, registers, and the reports of the last search
  logic [WeightW-1:0] mat_weight [MatDepth];
  logic               mat_edge   [MatDepth];
  bit                 loaded     [MatDepth];
  logic [CountW-1:0]  cfg_nodes  = NodeCountRst;
  logic [NodeW-1:0]   cfg_src    = StartNodeRst;
  logic [NodeW-1:0]   cfg_dst    = TargetNodeRst;
  out_item_t          search_reports [$];
  out_item_t          pending_reports [$];
  int                 fail_count = 0;
  int                 items_sent = 0;

  typedef struct packed {
    logic       cfg;
    logic [4:0] nodes;
    logic [3:0] src;
    logic [3:0] dst;
    in_item_t   entry;
    logic       typed;
    out_item_t  report;
  } dir_row_t;

  // Small graph on nodes 0..2: 0->1 (10), 0->2 (3), 2->1 (7, a tie), 1->2 (0), 2->0 (max)
  dir_row_t directed_rows [DirRows] = '{
    '{1'b1, 5'd1, 4'd0, 4'd15, '{4'd0, 4'd0, 16'hFFFF, 1'b1, 1'b1},
      1'b1, '{4'd0, 20'd0, 1'b1, 4'd0, 1'b1, 1'b1}},
    // target equals start: picked first, left unsettled
    '{1'b1, 5'd1, 4'd0, 4'd0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b1},
      1'b1, '{4'd0, 20'd0, 1'b1, 4'd0, 1'b0, 1'b1}},
    // zero node count acts as one; start outside nodes in use
    '{1'b1, 5'd0, 4'd9, 4'd15, '{4'd0, 4'd0, 16'h0005, 1'b1, 1'b1},
      1'b1, '{4'd0, 20'd0, 1'b0, 4'd0, 1'b0, 1'b1}},
    '{1'b1, 5'd3, 4'd0, 4'd15, '{4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd8, 4'd7, 16'h8000, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd0, 4'd0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd0, 4'd1, 16'd10, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd0, 4'd2, 16'd3, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd1, 4'd0, 16'hFFFF, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd1, 4'd1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd1, 4'd2, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd2, 4'd0, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd2, 4'd1, 16'd7, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd2, 4'd2, 16'h0000, 1'b0, 1'b1}, 1'b0, '0},
    '{1'b1, 5'd3, 4'd2, 4'd1, '{4'd1, 4'd2, 16'h0000, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b1, 5'd3, 4'd1, 4'd0, '{4'd1, 4'd0, 16'hFFFF, 1'b0, 1'b1}, 1'b0, '0},
    // drop 0->2, then 0->1: nodes 1 and 2 end up unreachable
    '{1'b1, 5'd3, 4'd0, 4'd15, '{4'd0, 4'd2, 16'd3, 1'b0, 1'b1}, 1'b0, '0},
    '{1'b0, 5'd0, 4'd0, 4'd0, '{4'd0, 4'd1, 16'd10, 1'b0, 1'b1}, 1'b0, '0}
  };

  function automatic int nodes_in_use(logic [CountW-1:0] count);
    if (count < 1) return 1;
    if (count > MaxNodes) return MaxNodes;
    return int'(count);
  endfunction

  // Store one matrix entry; on a marked entry run the search and queue one report per node
  function automatic void shortest_path_search(in_item_t e);
    logic [DistW-1:0] node_dist [MaxNodes];
    logic             known [MaxNodes];
    logic             seen [MaxNodes];
    logic [NodeW-1:0] prev [MaxNodes];
    logic [DistW:0]   cost;
    out_item_t        r;
    int               n;
    int               sel;
    int               idx;
    bit               found;
    bit               done;
    idx = int'({e.row_index, e.col_index});
    mat_weight[idx] = e.edge_weight;
    mat_edge[idx] = e.has_edge;
    loaded[idx] = 1'b1;
    search_reports.delete();
    if (!e.start_search) return;
    n = nodes_in_use(cfg_nodes);
    for (int i = 0; i < MaxNodes; i++) begin
      node_dist[i] = '0;
      known[i] = 1'b0;
      seen[i] = 1'b0;
      prev[i] = '0;
    end
    known[cfg_src] = 1'b1;
    done = 1'b0;
    while (!done) begin
      found = 1'b0;
      sel = 0;
      for (int i = 0; i < n; i++) begin
        if (!seen[i] && known[i] && (!found || node_dist[i] < node_dist[sel])) begin
          sel = i;
          found = 1'b1;
        end
      end
      if (!found || sel == int'(cfg_dst)) begin
        done = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          idx = sel * MaxNodes + i;
          if (!seen[i] && mat_edge[idx]) begin
            cost = {1'b0, node_dist[sel]} + (DistW + 1)'(mat_weight[idx]);
            if (cost > {1'b0, DistMax}) cost = {1'b0, DistMax};
            if (!known[i] || {1'b0, node_dist[i]} > cost) begin
              node_dist[i] = cost[DistW-1:0];
              known[i] = 1'b1;
              prev[i] = NodeW'(sel);
            end
          end
        end
        seen[sel] = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node_index = NodeW'(i);
      r.distance = known[i] ? node_dist[i] : '0;
      r.reachable = known[i];
      r.predecessor = known[i] ? prev[i] : '0;
      r.settled = seen[i];
      r.last_result = (i == n - 1);
      search_reports = {search_reports, r};
    end
  endfunction

  function automatic in_item_t rand_entry(int span, bit last);
    in_item_t e;
    e.row_index = NodeW'($urandom_range(0, span - 1));
    e.col_index = NodeW'($urandom_range(0, span - 1));
    case ($urandom_range(0, 5))
      0: e.edge_weight = '0;
      1: e.edge_weight = '1;
      2: e.edge_weight = WeightW'($urandom);
      default: e.edge_weight = WeightW'($urandom_range(1, 24));
    endcase
    e.has_edge = ($urandom_range(0, 2) != 0);
    e.start_search = last;
    return e;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_entry(in_item_t e, bit typed = 1'b0, out_item_t report = '0);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= e;
    do @(posedge clk_i); while (busy);
    items_sent++;
    shortest_path_search(e);
    if (typed && e.start_search) pending_reports = {pending_reports, report};
    else pending_reports = {pending_reports, search_reports};
    @(negedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers only change once every report is in and the block has gone quiet
  task automatic set_search_config(logic [4:0] nodes, logic [3:0] src, logic [3:0] dst);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    apb_write(RegNodeCount, ApbDataW'(nodes));
    apb_write(RegStartNode, ApbDataW'(src));
    apb_write(RegTargetNode, ApbDataW'(dst));
    cfg_nodes = nodes;
    cfg_src = src;
    cfg_dst = dst;
  endtask

  function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_count++;
    end
  endfunction

  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_reports.size() == 0) begin
        $error("node report with none outstanding: node %0d", result_o.node_index);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("node_index", 32'(want.node_index), 32'(result_o.node_index));
        check_field("distance", 32'(want.distance), 32'(result_o.distance));
        check_field("reachable", 32'(want.reachable), 32'(result_o.reachable));
        check_field("predecessor", 32'(want.predecessor), 32'(result_o.predecessor));
        check_field("settled", 32'(want.settled), 32'(result_o.settled));
        check_field("last_result", 32'(want.last_result), 32'(result_o.last_result));
      end
    end
  end

  // Watchdog: cycles without any transfer on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || result_strobe_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [4:0] nodes;
    logic [3:0] src;
    logic [3:0] dst;
    int         lim;
    int         phase_no;
    bit         full_done;
    in_item_t   fill;
    phase_no = 0;
    full_done = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        start <= 1'b0;
        set_search_config(directed_rows[i].nodes, directed_rows[i].src, directed_rows[i].dst);
      end
      send_entry(directed_rows[i].entry, directed_rows[i].typed, directed_rows[i].report);
    end
    start <= 1'b0;

    // Mostly complete loads followed by a search; phase 4 uses a full-matrix node count
    while (!full_done || items_sent < ItemsTarget) begin
      phase_no++;
      case ($urandom_range(0, 9))
        0: nodes = full_done ? 5'($urandom_range(16, 31)) : 5'($urandom_range(1, 6));
        1: nodes = '0;
        default: nodes = 5'($urandom_range(1, 6));
      endcase
      if (!full_done && phase_no == 4) begin
        nodes = 5'($urandom_range(16, 31));
        full_done = 1'b1;
      end
      lim = nodes_in_use(nodes);
      src = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, lim - 1));
      dst = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, lim - 1));
      set_search_config(nodes, src, dst);
      if ($urandom_range(0, 7) == 0) begin
        // stray writes anywhere, no search
        repeat ($urandom_range(1, 4)) send_entry(rand_entry(MaxNodes, 1'b0));
      end else begin
        for (int r = 0; r < lim; r++) begin
          for (int c = 0; c < lim; c++) begin
            if (!loaded[r * MaxNodes + c]) begin
              fill = rand_entry(1, 1'b0);
              fill.row_index = 4'(r);
              fill.col_index = 4'(c);
              send_entry(fill);
            end
          end
        end
        repeat ($urandom_range(0, 4)) begin
          send_entry(rand_entry(($urandom_range(0, 3) == 0) ? MaxNodes : lim, 1'b0));
        end
        send_entry(rand_entry(($urandom_range(0, 3) == 0) ? MaxNodes : lim, 1'b1));
      end
      start <= 1'b0;
    end

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/spms_pkg.sv
hdl/spms_ram.sv
hdl/spms_dp.sv
hdl/spms_ctrl.sv
hdl/shortest_path_matrix_search.sv
tb/sv/shortest_path_matrix_search_tb.sv
